/* src/text_console_writer_core_assert.svh */
// Assertion macros for the text console writer.
// Included by text_console_writer_core.sv; no other dependencies.
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check cons in the same cycle as ante.
`define TCW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check cons in the cycle after ante.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/tcw_pkg.sv */
// Shared types and constants of the text console writer.
// No dependencies; imported by the top level.
`default_nettype none

package tcw_pkg;

    // Input item modes
    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] TEXT_ATTR    = 8'h07;

    // Configuration register indexes
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_COLUMNS = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_ROWS    = 1'b1;

    localparam int COLS_REG_W = 7;
    localparam int ROWS_REG_W = 5;
    localparam int CFG_DATA_W = 7;
    localparam logic [COLS_REG_W-1:0] COLS_RESET = 7'd80;
    localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 5'd25;

    // Field widths
    localparam int MODE_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int READ_ROW_W = 5;
    localparam int READ_COL_W = 7;
    localparam int CURSOR_W   = 11;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 32;

    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] chr;
    } cell_t;

endpackage

`default_nettype wire

/* src/tcw_colmod.sv */
// Restoring remainder unit: dividend mod divisor, one dividend bit per cycle.
// Standalone; used by text_console_writer_core for the newline column.
`default_nettype none

module tcw_colmod #(
    parameter int DW = 11,
    parameter int CW = 7
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [CW-1:0] divisor,
    output logic               done,
    output logic [CW-1:0]      remainder
);

    localparam int IW = (DW > 1) ? $clog2(DW) : 1;

    logic          busy_reg;
    logic          done_reg;
    logic [IW-1:0] cnt_reg;
    logic [DW-1:0] shift_reg;
    logic [CW-1:0] rem_reg;
    logic [CW:0]   step_val;
    logic [CW:0]   step_diff;

    // Bring down the next dividend bit and subtract when it fits
    assign step_val  = {rem_reg, shift_reg[DW-1]};
    assign step_diff = step_val - {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg   <= IW'(DW - 1);
            shift_reg <= dividend;
            rem_reg   <= '0;
        end else if (busy_reg) begin
            cnt_reg   <= cnt_reg - 1'b1;
            shift_reg <= shift_reg << 1;
            if (step_val >= {1'b0, divisor}) begin
                rem_reg <= CW'(step_diff);
            end else begin
                rem_reg <= CW'(step_val);
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* src/text_console_writer_core.sv */
// Text console writer: cell buffer memory, cursor and put/clear/read sequencer.
// Depends on tcw_pkg, tcw_colmod and text_console_writer_core_assert.svh.
//
// The screen is held in one synchronous memory of MAX_COLS*MAX_ROWS cells
// (character in the low byte, attribute in the high byte) with a single
// registered read port and a single write port fed from a write stage.
// Each input transaction produces exactly one result transaction. Per item,
// from acceptance to the result being loaded: a plain put is decoded,
// checked and finished; a newline also waits for the column remainder
// unit; a read goes through the registered memory read, unless the cell lies
// outside the screen, which skips the memory, as does the unused mode; a put
// that runs off the screen end adds a copy sweep over the columns*rows cells
// in use; a clear sweeps all MAX_COLS*MAX_ROWS cells. The sweeps are set by
// the one memory write port. After reset the block clears the buffer with
// s_tready low; configuration writes are taken at any time, but must only
// change while no transaction is in flight. A new item is accepted while the
// previous result still waits in the output register.
`default_nettype none

`include "text_console_writer_core_assert.svh"

module text_console_writer_core #(
    parameter int MAX_COLS = 80,
    parameter int MAX_ROWS = 25
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input: char_code[7:0], read_row[12:8], read_col[19:13]
    input  wire logic [tcw_pkg::S_DATA_W-1:0]  s_tdata,
    // input: mode[1:0]
    input  wire logic [tcw_pkg::MODE_W-1:0]    s_tuser,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // result: cursor_position[10:0], did_scroll[11], cell_char[19:12],
    //         cell_attr[27:20]
    output logic [tcw_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // configuration write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tcw_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data
);

    import tcw_pkg::*;

    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PW    = $clog2(CELLS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_SCR  = 4'd4;
    localparam logic [3:0] S_CLR  = 4'd5;
    localparam logic [3:0] S_DRN  = 4'd6;
    localparam logic [3:0] S_RD   = 4'd7;
    localparam logic [3:0] S_RDD  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    // Control state
    logic [3:0]  state_reg, state_next;
    logic        init_reg, init_next;
    logic        sweep_scroll_reg, sweep_scroll_next;
    logic [AW-1:0] k_reg, k_next;
    logic [PW-1:0] cursor_reg, cursor_next;
    logic [COLS_REG_W-1:0] cols_reg, cols_next;
    logic [ROWS_REG_W-1:0] rows_reg, rows_next;
    logic        wr_en_reg, wr_en_next;
    logic        m_valid_reg, m_valid_next;

    // Item payload
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [CHAR_W-1:0]     ch_reg, ch_next;
    logic [READ_ROW_W-1:0] rr_reg, rr_next;
    logic [READ_COL_W-1:0] rc_reg, rc_next;
    logic [PW:0]           pos_reg, pos_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic                  scrolled_reg, scrolled_next;
    logic [7:0]            cchar_reg, cchar_next;
    logic [7:0]            cattr_reg, cattr_next;
    logic [M_DATA_W-1:0]   m_data_reg, m_data_next;

    // Write stage
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic          wr_copy_reg, wr_copy_next;
    cell_t         wr_data_reg, wr_data_next;

    // Screen memory
    cell_t         mem [CELLS];
    cell_t         rdata_reg;
    logic [AW-1:0] rd_addr;

    // Effective geometry, registered from the configuration registers
    logic [CW-1:0] ncols_eff, ncols_reg;
    logic [RW-1:0] nrows_eff, nrows_reg;
    logic [PW-1:0] total_reg, last_reg;
    logic [CW+RW-1:0] geo_prod;

    // Datapath helpers
    logic [READ_ROW_W+CW-1:0] rd_prod;
    logic [READ_ROW_W+CW:0]   rd_lin;
    logic                     rd_ok;
    logic [PW:0]              pos_nl;
    logic [AW:0]              scr_src;
    logic [CURSOR_W-1:0]      cursor_out;
    logic                     div_start;
    logic                     div_done;
    logic [CW-1:0]            div_rem;

    // Saturate the registers into the supported range
    always_comb begin
        if (cols_reg == '0) begin
            ncols_eff = CW'(1);
        end else if (int'(cols_reg) > MAX_COLS) begin
            ncols_eff = CW'(MAX_COLS);
        end else begin
            ncols_eff = CW'(cols_reg);
        end
        if (rows_reg == '0) begin
            nrows_eff = RW'(1);
        end else if (int'(rows_reg) > MAX_ROWS) begin
            nrows_eff = RW'(MAX_ROWS);
        end else begin
            nrows_eff = RW'(rows_reg);
        end
    end

    assign geo_prod = {{RW{1'b0}}, ncols_reg} * {{CW{1'b0}}, nrows_reg};

    always_ff @(posedge aclk) begin
        ncols_reg <= ncols_eff;
        nrows_reg <= nrows_eff;
        total_reg <= PW'(geo_prod);
        last_reg  <= PW'(geo_prod) - PW'(ncols_reg);
    end

    // Read address of a cell: row * columns + column
    assign rd_prod = {{CW{1'b0}}, rr_reg} * {{READ_ROW_W{1'b0}}, ncols_reg};
    assign rd_lin  = {1'b0, rd_prod} + (READ_ROW_W + CW + 1)'(rc_reg);
    assign rd_ok   = (rr_reg < nrows_reg) && (rc_reg < ncols_reg);

    // Start of the next row: cursor - (cursor mod columns) + columns
    assign pos_nl = pos_reg - (PW + 1)'(div_rem) + (PW + 1)'(ncols_reg);

    // Scroll source: the cell one row below
    assign scr_src = (AW + 1)'(k_reg) + (AW + 1)'(ncols_reg);

    assign rd_addr = (state_reg == S_SCR) ? AW'(scr_src) : addr_reg;

    assign cursor_out = CURSOR_W'(cursor_reg);

    tcw_colmod #(
        .DW (PW),
        .CW (CW)
    ) u_colmod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (cursor_reg),
        .divisor   (ncols_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb begin
        state_next        = state_reg;
        init_next         = init_reg;
        sweep_scroll_next = sweep_scroll_reg;
        k_next            = k_reg;
        cursor_next       = cursor_reg;
        cols_next         = cols_reg;
        rows_next         = rows_reg;
        mode_next         = mode_reg;
        ch_next           = ch_reg;
        rr_next           = rr_reg;
        rc_next           = rc_reg;
        pos_next          = pos_reg;
        addr_next         = addr_reg;
        scrolled_next     = scrolled_reg;
        cchar_next        = cchar_reg;
        cattr_next        = cattr_reg;
        wr_en_next        = 1'b0;
        wr_addr_next      = wr_addr_reg;
        wr_copy_next      = 1'b0;
        wr_data_next      = wr_data_reg;
        div_start         = 1'b0;
        m_valid_next      = m_valid_reg & ~m_tready;
        m_data_next       = m_data_reg;

        case (state_reg)
            S_IDLE: begin
                // Capture the transaction and snapshot the cursor
                if (s_tvalid) begin
                    mode_next     = s_tuser;
                    ch_next       = s_tdata[7:0];
                    rr_next       = s_tdata[12:8];
                    rc_next       = s_tdata[19:13];
                    pos_next      = {1'b0, cursor_reg};
                    scrolled_next = 1'b0;
                    cchar_next    = '0;
                    cattr_next    = '0;
                    state_next    = S_DEC;
                end
            end
            S_DEC: begin
                case (mode_reg)
                    MODE_PUT: begin
                        if (ch_reg == CHAR_NEWLINE) begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end else begin
                            state_next = S_CHK;
                        end
                    end
                    MODE_CLEAR: begin
                        k_next            = '0;
                        sweep_scroll_next = 1'b0;
                        state_next        = S_CLR;
                    end
                    MODE_READ: begin
                        // Cells outside the screen read as zero
                        if (rd_ok) begin
                            addr_next  = AW'(rd_lin);
                            state_next = S_RD;
                        end else begin
                            state_next = S_FIN;
                        end
                    end
                    default: begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    pos_next   = pos_nl;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (pos_reg >= {1'b0, total_reg}) begin
                    // Off the screen end: scroll first
                    k_next            = '0;
                    sweep_scroll_next = 1'b1;
                    scrolled_next     = 1'b1;
                    state_next        = S_SCR;
                end else if (ch_reg == CHAR_NEWLINE) begin
                    cursor_next = PW'(pos_reg);
                    state_next  = S_FIN;
                end else begin
                    wr_en_next   = 1'b1;
                    wr_addr_next = AW'(pos_reg);
                    wr_data_next = '{attr: TEXT_ATTR, chr: ch_reg};
                    cursor_next  = PW'(pos_reg + 1'b1);
                    state_next   = S_FIN;
                end
            end
            S_SCR: begin
                // Copy rows up one; zero the last row
                wr_en_next   = 1'b1;
                wr_addr_next = k_reg;
                wr_copy_next = (k_reg < last_reg);
                wr_data_next = '0;
                if (k_reg == AW'(total_reg - 1'b1)) begin
                    state_next = S_DRN;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_CLR: begin
                wr_en_next   = 1'b1;
                wr_addr_next = k_reg;
                wr_data_next = '0;
                if (k_reg == AW'(CELLS - 1)) begin
                    state_next = S_DRN;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_DRN: begin
                // Last sweep write lands this cycle
                if (sweep_scroll_reg) begin
                    cursor_next = last_reg;
                    pos_next    = {1'b0, last_reg};
                    state_next  = S_CHK;
                end else if (init_reg) begin
                    init_next  = 1'b0;
                    state_next = S_IDLE;
                end else begin
                    cursor_next = '0;
                    state_next  = S_FIN;
                end
            end
            S_RD: begin
                state_next = S_RDD;
            end
            S_RDD: begin
                cchar_next = rdata_reg.chr;
                cattr_next = rdata_reg.attr;
                state_next = S_FIN;
            end
            S_FIN: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0, cattr_reg, cchar_reg, scrolled_reg, cursor_out};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid) begin
            case (cfg_index)
                REG_COLUMNS: cols_next = cfg_data[COLS_REG_W-1:0];
                REG_ROWS:    rows_next = cfg_data[ROWS_REG_W-1:0];
                default:     cols_next = cols_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_CLR;
            init_reg         <= 1'b1;
            sweep_scroll_reg <= 1'b0;
            k_reg            <= '0;
            cursor_reg       <= '0;
            cols_reg         <= COLS_RESET;
            rows_reg         <= ROWS_RESET;
            wr_en_reg        <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            init_reg         <= init_next;
            sweep_scroll_reg <= sweep_scroll_next;
            k_reg            <= k_next;
            cursor_reg       <= cursor_next;
            cols_reg         <= cols_next;
            rows_reg         <= rows_next;
            wr_en_reg        <= wr_en_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        ch_reg       <= ch_next;
        rr_reg       <= rr_next;
        rc_reg       <= rc_next;
        pos_reg      <= pos_next;
        addr_reg     <= addr_next;
        scrolled_reg <= scrolled_next;
        cchar_reg    <= cchar_next;
        cattr_reg    <= cattr_next;
        m_data_reg   <= m_data_next;
        wr_addr_reg  <= wr_addr_next;
        wr_copy_reg  <= wr_copy_next;
        wr_data_reg  <= wr_data_next;
    end

    // Screen memory: registered read, write from the write stage. A scroll
    // write takes the cell from the row below, read into rdata_reg in the cycle before.
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[rd_addr];
        if (wr_en_reg) begin
            mem[wr_addr_reg] <= wr_copy_reg ? rdata_reg : wr_data_reg;
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // The write stage is empty whenever a new transaction is taken
    `TCW_ASSERT_SAME(a_wr_drained, aclk, aresetn, s_tvalid && s_tready, !wr_en_reg, "write pending at accept")
    // An accepted transaction is decoded in the next cycle
    `TCW_ASSERT_NEXT(a_accept_dec, aclk, aresetn, s_tvalid && s_tready, state_reg == S_DEC, "accept did not decode")
    // The scroll sweep never runs past the screen in use
    `TCW_ASSERT_SAME(a_scr_bound, aclk, aresetn, state_reg == S_SCR, k_reg < total_reg, "scroll sweep overrun")

endmodule

`default_nettype wire

/* tb/sv/console_shadow_check.sv */
// Shadow screen model and result comparison for the text console writer bench.
// Depends on tcw_pkg; instantiated beside the block by text_console_writer_core_test.
module console_shadow_check #(
    parameter int MAX_COLS = 80,
    parameter int MAX_ROWS = 25
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [tcw_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [tcw_pkg::MODE_W-1:0]     s_tuser,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [tcw_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [tcw_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatch_count,
    output int                             pending_count,
    output int                             scroll_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int CELLS = MAX_COLS * MAX_ROWS;

    // Same bit layout as m_tdata[27:0]
    typedef struct packed {
        logic [CHAR_W-1:0]   attr;
        logic [CHAR_W-1:0]   chr;
        logic                scrolled;
        logic [CURSOR_W-1:0] cursor_pos;
    } step_result_t;

    cell_t                 shadow_screen [CELLS];
    int unsigned           shadow_cursor;
    logic [COLS_REG_W-1:0] cols_reg;
    logic [ROWS_REG_W-1:0] rows_reg;
    step_result_t          pending_results [$];
    int                    results_seen;

    function automatic void report_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t ns: %s", $time, msg);
    endfunction

    // Advance the shadow screen by one input item and return the result it yields.
    function automatic step_result_t predict_console_step(logic [MODE_W-1:0]   kind,
                                                          logic [S_DATA_W-1:0] item);
        logic [MODE_W-1:0]     mode;
        logic [CHAR_W-1:0]     code;
        logic [READ_ROW_W-1:0] rd_row;
        logic [READ_COL_W-1:0] rd_col;
        int unsigned           nc;
        int unsigned           nr;
        int unsigned           span;
        int unsigned           i;
        step_result_t          res;
        mode   = kind;
        code   = item[7:0];
        rd_row = item[12:8];
        rd_col = item[19:13];
        // saturate the geometry registers into the buffer size
        nc = (cols_reg == 0) ? 1 : (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
        nr = (rows_reg == 0) ? 1 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
        span = nc * nr;
        res = '0;
        case (mode)
            MODE_PUT: begin
                if (code == CHAR_NEWLINE)
                    shadow_cursor = shadow_cursor - (shadow_cursor % nc) + nc;
                // a cursor at or past the end (also a stale one) scrolls first
                if (shadow_cursor >= span) begin
                    for (i = 0; i < nc * (nr - 1); i++)
                        shadow_screen[i] = shadow_screen[i + nc];
                    for (i = nc * (nr - 1); i < span; i++)
                        shadow_screen[i] = '0;
                    shadow_cursor = nc * (nr - 1);
                    res.scrolled = 1'b1;
                end
                if (code != CHAR_NEWLINE) begin
                    shadow_screen[shadow_cursor] = {TEXT_ATTR, code};
                    shadow_cursor++;
                end
            end
            MODE_CLEAR: begin
                for (i = 0; i < CELLS; i++)
                    shadow_screen[i] = '0;
                shadow_cursor = 0;
            end
            MODE_READ: begin
                if (rd_row < nr && rd_col < nc) begin
                    res.chr  = shadow_screen[rd_row * nc + rd_col].chr;
                    res.attr = shadow_screen[rd_row * nc + rd_col].attr;
                end
            end
            default: ;
        endcase
        res.cursor_pos = shadow_cursor[CURSOR_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        step_result_t got;
        step_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < CELLS; i++)
                shadow_screen[i] = '0;
            shadow_cursor = 0;
            cols_reg = COLS_RESET;
            rows_reg = ROWS_RESET;
            pending_results.delete();
        end else begin
            // retire the oldest prediction before queueing a new one
            if (m_tvalid && m_tready) begin
                got = m_tdata[27:0];
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_failure($sformatf("result %0d arrived with nothing pending",
                                             results_seen));
                end else begin
                    want = pending_results.pop_front();
                    if (want.scrolled)
                        scroll_count++;
                    if (got.cursor_pos !== want.cursor_pos)
                        report_failure($sformatf("result %0d cursor_position: exp %0d got %0d",
                                                 results_seen, want.cursor_pos, got.cursor_pos));
                    if (got.scrolled !== want.scrolled)
                        report_failure($sformatf("result %0d did_scroll: exp %0d got %0d",
                                                 results_seen, want.scrolled, got.scrolled));
                    if (got.chr !== want.chr)
                        report_failure($sformatf("result %0d cell_char: exp 0x%02h got 0x%02h",
                                                 results_seen, want.chr, got.chr));
                    if (got.attr !== want.attr)
                        report_failure($sformatf("result %0d cell_attr: exp 0x%02h got 0x%02h",
                                                 results_seen, want.attr, got.attr));
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(predict_console_step(s_tuser, s_tdata));
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_COLUMNS)
                    cols_reg = cfg_data[COLS_REG_W-1:0];
                else if (cfg_index == REG_ROWS)
                    rows_reg = cfg_data[ROWS_REG_W-1:0];
            end
        end
        pending_count <= pending_results.size();
    end

endmodule

/* tb/sv/text_console_writer_core_test.sv */
// Top of the text console writer bench: clock, reset, stimulus and verdict.
// Depends on tcw_pkg, text_console_writer_core and console_shadow_check.
module text_console_writer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int     MAX_COLS      = 80;
    localparam int     MAX_ROWS      = 25;
    localparam int     CLK_PERIOD    = 10;
    localparam int     RESET_CYCLES  = 5;
    localparam int     IDLE_PCT      = 24;
    localparam int     HOLD_CYCLES   = 120;
    localparam int     SETTLE_CYCLES = 40;
    // Worst case: ~450 items, each a full-buffer sweep plus stalls, taken ~3x over
    localparam longint TIMEOUT_NS    = 30_000_000;
    // Mode code the block leaves unused
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [MODE_W-1:0]     s_tuser   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [REG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatch_count;
    int pending_count;
    int scroll_count;

    // Stimulus shaping shared with the result sink
    bit          no_idle       = 1'b0;
    int unsigned hold_requests = 0;
    int          eff_cols      = MAX_COLS;
    int          eff_rows      = MAX_ROWS;

    // Run statistics for the closing summary
    int settings_used = 1;
    int n_put, n_newline, n_read, n_clear, n_unused;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    text_console_writer_core #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    console_shadow_check #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) shadow_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .scroll_count   (scroll_count)
    );

    // Offer one item and hold it until the block takes it. Optionally idle
    // first so gaps land on every phase of the block's work.
    task automatic send_item(input logic [MODE_W-1:0]     mode,
                             input logic [CHAR_W-1:0]     code,
                             input logic [READ_ROW_W-1:0] row,
                             input logic [READ_COL_W-1:0] col);
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        // tdata: char_code, read_row, read_col from bit 0 up, zero pad on top
        s_tdata  <= {{(S_DATA_W - 20){1'b0}}, col, row, code};
        s_tuser  <= mode;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        case (mode)
            MODE_PUT: begin
                n_put++;
                if (code == CHAR_NEWLINE)
                    n_newline++;
            end
            MODE_CLEAR: n_clear++;
            MODE_READ:  n_read++;
            default:    n_unused++;
        endcase
    endtask

    // Drop valid and hold until every predicted result has come back. The
    // first edge lets the checker count a transaction taken at this edge.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    // Write both geometry registers back to back; only call while drained.
    task automatic set_geometry(input logic [CFG_DATA_W-1:0] cols,
                                input logic [CFG_DATA_W-1:0] rows_val);
        cfg_valid <= 1'b1;
        cfg_index <= REG_COLUMNS;
        cfg_data  <= cols;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= REG_ROWS;
        cfg_data  <= rows_val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        // track the geometry in use so random reads mostly land on screen
        eff_cols = (cols == 0) ? 1 : (cols > MAX_COLS) ? MAX_COLS : cols;
        eff_rows = (rows_val[4:0] == 0) ? 1 :
                   (rows_val[4:0] > MAX_ROWS) ? MAX_ROWS : rows_val[4:0];
        settings_used++;
    endtask

    // Mostly puts (newline share set by nl_pct), then reads, a few clears and
    // some unused-mode noise. Unused fields carry random bits throughout.
    task automatic send_random(input int nl_pct);
        int unsigned           pick;
        logic [CHAR_W-1:0]     code;
        logic [READ_ROW_W-1:0] row;
        logic [READ_COL_W-1:0] col;
        pick = $urandom_range(99);
        code = CHAR_W'($urandom_range(255));
        row  = READ_ROW_W'($urandom);
        col  = READ_COL_W'($urandom);
        if (pick < 70) begin
            if ($urandom_range(99) < nl_pct)
                code = CHAR_NEWLINE;
            send_item(MODE_PUT, code, row, col);
        end else if (pick < 93) begin
            // three reads in four inside the screen, the rest anywhere
            if ($urandom_range(3) != 0) begin
                row = READ_ROW_W'($urandom_range(eff_rows - 1));
                col = READ_COL_W'($urandom_range(eff_cols - 1));
            end
            send_item(MODE_READ, code, row, col);
        end else if (pick < 95) begin
            send_item(MODE_CLEAR, code, row, col);
        end else begin
            send_item(MODE_UNUSED, code, row, col);
        end
    endtask

    task automatic run_items(input int count, input int nl_pct);
        repeat (count) send_random(nl_pct);
    endtask

    // Result sink: random backpressure, plus a long hold-off whenever the
    // stimulus asks for one, counted here so the sender keeps offering items.
    initial begin : result_sink
        int unsigned served;
        served = 0;
        forever begin
            @(posedge aclk);
            if (hold_requests != served) begin
                served++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset geometry of 80 x 25. The block clears its
        // buffer after reset, so the first transaction waits for s_tready.
        send_item(MODE_READ, 8'h00, 5'd0, 7'd0);            // blank cell after reset
        send_item(MODE_PUT, 8'h41, 5'd0, 7'd0);
        send_item(MODE_PUT, 8'hFF, 5'd31, 7'd127);          // top char code
        send_item(MODE_PUT, 8'h00, 5'd0, 7'd0);             // bottom char code
        send_item(MODE_PUT, CHAR_NEWLINE, 5'd0, 7'd0);
        send_item(MODE_PUT, 8'h5A, 5'd0, 7'd0);
        send_item(MODE_READ, 8'h00, 5'd0, 7'd1);
        send_item(MODE_READ, 8'h00, 5'd1, 7'd0);
        send_item(MODE_READ, 8'h00, 5'd24, 7'd79);          // last cell on screen
        send_item(MODE_READ, 8'hFF, 5'd31, 7'd127);         // far outside the screen
        send_item(MODE_READ, 8'h00, 5'd25, 7'd0);           // one row past the end
        send_item(MODE_READ, 8'h00, 5'd0, 7'd80);           // one column past the end
        send_item(MODE_UNUSED, 8'hFF, 5'd31, 7'd127);       // unused mode changes nothing
        send_item(MODE_CLEAR, 8'h00, 5'd0, 7'd0);
        send_item(MODE_READ, 8'h00, 5'd0, 7'd0);
        send_item(MODE_PUT, 8'h48, 5'd0, 7'd0);
        send_item(MODE_PUT, CHAR_NEWLINE, 5'd0, 7'd0);
        send_item(MODE_PUT, 8'h58, 5'd0, 7'd0);
        wait_drained();

        // Shrink to 3 x 2 with the cursor left far past the new end: the
        // next put has to scroll before it stores.
        set_geometry(7'd3, 7'd2);
        send_item(MODE_PUT, 8'h42, 5'd0, 7'd0);
        send_item(MODE_PUT, 8'h43, 5'd0, 7'd0);
        send_item(MODE_PUT, 8'h44, 5'd0, 7'd0);
        send_item(MODE_PUT, 8'h45, 5'd0, 7'd0);              // runs off the end, scrolls
        send_item(MODE_PUT, CHAR_NEWLINE, 5'd0, 7'd0);       // newline on last row scrolls
        send_item(MODE_READ, 8'h00, 5'd0, 7'd2);
        send_item(MODE_READ, 8'h00, 5'd1, 7'd0);
        wait_drained();

        // Random part. The sink holds off partway through the first phase
        // while items keep coming, so the block fills and stalls its input.
        set_geometry(7'd5, 7'd3);
        run_items(10, 15);
        hold_requests++;
        run_items(30, 15);
        wait_drained();

        set_geometry(7'd1, 7'd1);                            // almost every put scrolls
        run_items(25, 20);
        wait_drained();

        set_geometry(7'd0, 7'd0);                            // zero saturates to 1 x 1
        run_items(20, 20);
        wait_drained();

        // Oversized values saturate to the full 80 x 25; the rows write also
        // carries bits above the register width. Heavy newlines reach the
        // last row and force full-screen scrolls.
        set_geometry(7'd127, 7'h7F);
        run_items(90, 55);
        wait_drained();

        set_geometry(7'd80, 7'd25);
        run_items(40, 40);
        wait_drained();

        // Sender pauses mid-phase until everything has come back.
        set_geometry(7'd2, 7'd4);
        run_items(20, 15);
        wait_drained();
        run_items(20, 15);
        wait_drained();

        // Long stretch with no idling on either side.
        no_idle = 1'b1;
        set_geometry(7'd7, 7'd1);
        run_items(50, 10);
        wait_drained();
        no_idle = 1'b0;

        set_geometry(7'd1, 7'd5);
        run_items(30, 10);
        wait_drained();

        repeat (3) begin
            set_geometry(CFG_DATA_W'($urandom_range(1, 12)),
                         CFG_DATA_W'($urandom_range(1, 6)));
            run_items(30, 20);
            wait_drained();
        end

        // Let any stray result show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d puts (%0d newlines), %0d reads, %0d clears, %0d unused-mode items",
                 n_put, n_newline, n_read, n_clear, n_unused);
        $display("with %0d scrolls across %0d screen geometries, saturated ones included",
                 scroll_count, settings_used);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
